/* sv/tte_pkg.sv */
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types and constants for the table trellis encoder and packer.
// ----------------------------------------------------------------------------
package tte_pkg;

    // Largest block length; longer counts are clamped to this
    localparam int MaxBlockSymbols = 1024;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_SYMBOL_BITS = 2'd0;
    localparam logic [1:0] REG_TABLE_0     = 2'd1;
    localparam logic [1:0] REG_TABLE_1     = 2'd2;
    localparam logic [1:0] REG_TABLE_2     = 2'd3;

    // 32 entries of 6 bits: [5:3] output bits, [2:0] next trellis state
    typedef logic [31:0][5:0] t_table;

    // Working state of one encoding step
    typedef struct packed {
        logic [23:0] in_bits;
        logic [4:0]  in_cnt;
        logic [23:0] out_bits;
        logic [4:0]  out_cnt;
        logic [2:0]  trellis;
    } t_enc_state;

    // Result of one pass through the symbol unit
    typedef struct packed {
        t_enc_state  nxt;
        logic        emit;
        logic [15:0] word;
        logic [15:0] pad_word;
    } t_enc_res;

endpackage

/* sv/tte_cfg.sv */
// ----------------------------------------------------------------------------
// tte_cfg
// APB register file: symbol width and the packed 32-entry trellis table.
// ----------------------------------------------------------------------------
module tte_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    output logic [2:0]         o_symbol_bits,
    output tte_pkg::t_table    o_table
);

    logic [2:0]  r_symbol_bits;
    logic [63:0] r_table_0;
    logic [63:0] r_table_1;
    logic [63:0] r_table_2;
    logic        w_wr;
    logic [1:0]  w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[4:3];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_bits <= 3'd6;
            r_table_0     <= '0;
            r_table_1     <= '0;
            r_table_2     <= '0;
        end else if (w_wr) begin
            case (w_idx)
                tte_pkg::REG_SYMBOL_BITS: r_symbol_bits <= pwdata[2:0];
                tte_pkg::REG_TABLE_0:     r_table_0     <= pwdata;
                tte_pkg::REG_TABLE_1:     r_table_1     <= pwdata;
                tte_pkg::REG_TABLE_2:     r_table_2     <= pwdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            tte_pkg::REG_SYMBOL_BITS: prdata = {61'd0, r_symbol_bits};
            tte_pkg::REG_TABLE_0:     prdata = r_table_0;
            tte_pkg::REG_TABLE_1:     prdata = r_table_1;
            tte_pkg::REG_TABLE_2:     prdata = r_table_2;
            default:                  prdata = '0;
        endcase
    end

    assign o_symbol_bits = r_symbol_bits;
    // the three parts concatenate to exactly 32 x 6 bits
    assign o_table       = {r_table_2, r_table_1, r_table_0};

endmodule

/* sv/tte_sym_unit.sv */
// ----------------------------------------------------------------------------
// tte_sym_unit
// Shared symbol unit: cuts one symbol, runs the trellis lookup, packs it.
// ----------------------------------------------------------------------------
module tte_sym_unit (
    input  tte_pkg::t_enc_state i_st,
    input  logic [2:0]          i_n,
    input  tte_pkg::t_table     i_table,
    output tte_pkg::t_enc_res   o_res
);

    logic [4:0]  w_icnt;
    logic [23:0] w_sym_all;
    logic [5:0]  w_sym;
    logic [23:0] w_in_rem;
    logic [2:0]  w_nm2;
    logic [5:0]  w_dib_all;
    logic [1:0]  w_dibit;
    logic [5:0]  w_entry;
    logic [6:0]  w_osym;
    logic [3:0]  w_np1;
    logic [23:0] w_obits;
    logic [4:0]  w_ocnt;
    logic [4:0]  w_ocnt2;
    logic        w_emit;
    logic [23:0] w_word_all;
    logic [23:0] w_pad_all;

    // cut the next symbol off the top of the input bits
    assign w_icnt    = i_st.in_cnt - {2'b00, i_n};
    assign w_sym_all = i_st.in_bits >> w_icnt;
    assign w_sym     = w_sym_all[5:0] & ((6'd1 << i_n) - 6'd1);
    assign w_in_rem  = i_st.in_bits & ((24'd1 << w_icnt) - 24'd1);

    // dibit and trellis state select the table entry
    assign w_nm2     = i_n - 3'd2;
    assign w_dib_all = w_sym >> w_nm2;
    assign w_dibit   = w_dib_all[1:0];
    assign w_entry   = i_table[{i_st.trellis, w_dibit}];

    // output symbol: coded bits over the uncoded low bits
    assign w_osym = ({4'd0, w_entry[5:3]} << w_nm2)
                  | ({1'b0, w_sym} & ((7'd1 << w_nm2) - 7'd1));

    // append to the output bits, split off a full word
    assign w_np1      = {1'b0, i_n} + 4'd1;
    assign w_obits    = (i_st.out_bits << w_np1) | {17'd0, w_osym};
    assign w_ocnt     = i_st.out_cnt + {1'b0, w_np1};
    assign w_emit     = w_ocnt >= 5'd16;
    assign w_ocnt2    = w_emit ? (w_ocnt - 5'd16) : w_ocnt;
    assign w_word_all = w_obits >> w_ocnt2;

    // partial word, zero padded at the bottom
    assign w_pad_all  = i_st.out_bits << (5'd16 - i_st.out_cnt);

    always_comb begin
        o_res.nxt.in_bits  = w_in_rem;
        o_res.nxt.in_cnt   = w_icnt;
        o_res.nxt.out_bits = w_emit ? (w_obits & ((24'd1 << w_ocnt2) - 24'd1)) : w_obits;
        o_res.nxt.out_cnt  = w_ocnt2;
        o_res.nxt.trellis  = w_entry[2:0];
        o_res.emit         = w_emit;
        o_res.word         = w_word_all[15:0];
        o_res.pad_word     = w_pad_all[15:0];
    end

endmodule

/* sv/table_trellis_encoder_packer.sv */
// ----------------------------------------------------------------------------
// table_trellis_encoder_packer
// Table-driven trellis encoder: cuts a 16-bit word stream into N-bit symbols,
// encodes the top dibit through a 32-entry state table and packs the N+1-bit
// results into 16-bit output words.
//
// Usage
//   Input channel (i_valid / o_stall) takes one 16-bit word per request;
//   i_first_word starts a block of i_block_symbols symbols. Output channel
//   (o_valid / i_stall) returns zero to three words per input request, the
//   last one flagged by o_last; o_block_end marks words of the closing step.
//   Steps: the word is taken, then symbols pass one per cycle through the shared
//   symbol unit (up to 8 at N=2, 3 at N=6), the step is closed, then output
//   words go out one per cycle while the receiver does not stall. A word that
//   is ignored or opens an empty block is taken with no run; the single symbol
//   unit handles one symbol at a time. The input is stalled from acceptance
//   until the last result is taken, or until the step closes if it has none.
//   A receiver stall simply holds the current output word.
//   Reset clears trellis state, bit buffers and block status; registers
//   return to N=6 and an all-zero table. Configure only while idle.
// ----------------------------------------------------------------------------
module table_trellis_encoder_packer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // input request
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_in_word,
    input  logic        i_first_word,
    input  logic [10:0] i_block_symbols,
    // output request
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_out_word,
    output logic        o_last,
    output logic        o_block_end
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [2:0]           w_cfg_n;
    tte_pkg::t_table      w_table;
    tte_pkg::t_enc_res    w_res;

    logic [1:0]           r_state, n_state;
    tte_pkg::t_enc_state  r_st, n_st;
    logic [10:0]          r_rem, n_rem;
    logic                 r_active, n_active;
    logic [2:0]           r_n, n_n;
    logic [1:0]           r_nres, n_nres;
    logic [1:0]           r_rd, n_rd;
    logic                 r_ended, n_ended;
    logic [15:0]          r_buf [3];

    logic                 w_in_acc;
    logic                 w_out_acc;
    logic [2:0]           w_nsel;
    logic [10:0]          w_cnt;
    logic                 w_sym_go;
    logic                 w_we;
    logic [15:0]          w_wdata;

    tte_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_symbol_bits (w_cfg_n),
        .o_table       (w_table)
    );

    tte_sym_unit u_sym (
        .i_st    (r_st),
        .i_n     (r_n),
        .i_table (w_table),
        .o_res   (w_res)
    );

    // handshakes
    assign o_stall   = (r_state != S_IDLE);
    assign w_in_acc  = i_valid & ~o_stall;
    assign o_valid   = (r_state == S_DRAIN);
    assign w_out_acc = o_valid & ~i_stall;

    assign o_out_word  = r_buf[r_rd];
    assign o_last      = (r_rd == (r_nres - 2'd1));
    assign o_block_end = r_ended;

    // symbol width clamp and block length clamp
    assign w_nsel = (w_cfg_n < 3'd2) ? 3'd2 : ((w_cfg_n == 3'd7) ? 3'd6 : w_cfg_n);
    assign w_cnt  = (32'(i_block_symbols) > tte_pkg::MaxBlockSymbols)
                  ? 11'(tte_pkg::MaxBlockSymbols) : i_block_symbols;
    assign w_sym_go = (r_st.in_cnt >= {2'b00, r_n}) && (r_rem != 11'd0);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_st     = r_st;
        n_rem    = r_rem;
        n_active = r_active;
        n_n      = r_n;
        n_nres   = r_nres;
        n_rd     = r_rd;
        n_ended  = r_ended;
        w_we     = 1'b0;
        w_wdata  = w_res.word;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_n    = w_nsel;
                    n_nres = 2'd0;
                    if (i_first_word) begin
                        n_rem         = w_cnt;
                        n_active      = (w_cnt != 11'd0);
                        n_st.in_bits  = {8'd0, i_in_word};
                        n_st.in_cnt   = 5'd16;
                        n_st.out_bits = '0;
                        n_st.out_cnt  = '0;
                        if (w_cnt != 11'd0) begin
                            n_state = S_RUN;
                        end else begin
                            n_st.in_bits = '0;
                            n_st.in_cnt  = '0;
                        end
                    end else if (r_active) begin
                        n_st.in_bits = {r_st.in_bits[7:0], i_in_word};
                        n_st.in_cnt  = r_st.in_cnt + 5'd16;
                        n_state      = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (w_sym_go) begin
                    // one symbol per cycle
                    n_st  = w_res.nxt;
                    n_rem = r_rem - 11'd1;
                    if (w_res.emit) begin
                        w_we   = 1'b1;
                        n_nres = r_nres + 2'd1;
                    end
                end else begin
                    // close the step; flush the block if it is complete
                    n_ended = (r_rem == 11'd0);
                    n_rd    = 2'd0;
                    if (r_rem == 11'd0) begin
                        if (r_st.out_cnt != 5'd0) begin
                            w_we    = 1'b1;
                            w_wdata = w_res.pad_word;
                            n_nres  = r_nres + 2'd1;
                        end
                        n_st.in_bits  = '0;
                        n_st.in_cnt   = '0;
                        n_st.out_bits = '0;
                        n_st.out_cnt  = '0;
                        n_active      = 1'b0;
                    end
                    n_state = (n_nres != 2'd0) ? S_DRAIN : S_IDLE;
                end
            end
            S_DRAIN: begin
                if (w_out_acc) begin
                    n_rd = r_rd + 2'd1;
                    if (o_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_st     <= '0;
            r_rem    <= '0;
            r_active <= 1'b0;
            r_n      <= 3'd6;
            r_nres   <= '0;
            r_rd     <= '0;
            r_ended  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_st     <= n_st;
            r_rem    <= n_rem;
            r_active <= n_active;
            r_n      <= n_n;
            r_nres   <= n_nres;
            r_rd     <= n_rd;
            r_ended  <= n_ended;
        end
    end

    // result buffer, at most three words per request
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_buf[r_nres] <= w_wdata;
        end
    end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for table_trellis_encoder_packer. A short table of
// directed words covers reset behaviour, clamped and out-of-range settings,
// idle words, zero-length and restarted blocks. Six random phases then follow,
// each with its own symbol width and state table. Every accepted input request
// runs through a local trellis encoder model. Its output words, or the typed
// answer of some directed rows, are queued and checked in order on output.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 4000;   // cycles with no request moving
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off
    localparam int SETTLE      = 20;     // covers a full step with no output
    localparam int TAIL        = 30;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 16;
    localparam int N_DIRECTED  = 23;

    // table load modes
    localparam int TBL_KEEP = 0;
    localparam int TBL_RAND = 1;
    localparam int TBL_ONES = 2;
    localparam int TBL_ZERO = 3;

    typedef struct packed {
        logic [15:0] word;
        logic        last;
        logic        blk_end;
    } t_enc_word;

    // one directed request; typed_n < 0 means the model supplies the answer
    typedef struct packed {
        logic [15:0] word;
        logic        first;
        logic [10:0] cnt;
        int          set_n;
        int          tbl_mode;
        int          typed_n;
        logic [15:0] typed_word;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [N_DIRECTED] = '{
        // reset settings: N=6, all-zero table
        '{16'hFFFF, 1'b1, 11'd1,    -1, TBL_KEEP,  1, 16'h1E00},
        '{16'h1234, 1'b0, 11'd5,    -1, TBL_KEEP,  0, 16'h0000},  // idle word
        '{16'hABCD, 1'b1, 11'd0,    -1, TBL_KEEP,  0, 16'h0000},  // empty block
        '{16'h0000, 1'b1, 11'd1,    -1, TBL_KEEP,  1, 16'h0000},
        // oversized count, then restart mid-block
        '{16'hFFFF, 1'b1, 11'd2047,  6, TBL_RAND, -1, 16'h0000},
        '{16'h0000, 1'b0, 11'd0,    -1, TBL_KEEP, -1, 16'h0000},
        '{16'h8001, 1'b0, 11'd0,    -1, TBL_KEEP, -1, 16'h0000},
        '{16'h5A5A, 1'b1, 11'd3,    -1, TBL_KEEP, -1, 16'h0000},
        // widths 2 to 5, each in range
        '{16'hC3A5, 1'b1, 11'd12,    2, TBL_KEEP, -1, 16'h0000},
        '{16'hFFFF, 1'b0, 11'd0,    -1, TBL_KEEP, -1, 16'h0000},
        '{16'h1357, 1'b1, 11'd10,    3, TBL_KEEP, -1, 16'h0000},
        '{16'h2468, 1'b0, 11'd0,    -1, TBL_KEEP, -1, 16'h0000},
        '{16'hF00F, 1'b1, 11'd4,    -1, TBL_KEEP, -1, 16'h0000},  // exact word, no pad
        '{16'hF0F0, 1'b1, 11'd1024,  4, TBL_KEEP, -1, 16'h0000},
        '{16'h0F0F, 1'b0, 11'd0,    -1, TBL_KEEP, -1, 16'h0000},
        '{16'hFFFF, 1'b1, 11'd6,     5, TBL_KEEP, -1, 16'h0000},
        '{16'h0000, 1'b0, 11'd0,    -1, TBL_KEEP, -1, 16'h0000},
        // widths out of range
        '{16'h9999, 1'b1, 11'd8,     0, TBL_KEEP, -1, 16'h0000},
        '{16'h6666, 1'b1, 11'd3,     1, TBL_KEEP, -1, 16'h0000},
        '{16'hFFFF, 1'b1, 11'd4,     7, TBL_ONES, -1, 16'h0000},
        // long block; count on a follow-on word is ignored
        '{16'h0001, 1'b1, 11'd1024,  6, TBL_RAND, -1, 16'h0000},
        '{16'h8000, 1'b0, 11'd2047, -1, TBL_KEEP, -1, 16'h0000},
        '{16'h7FFF, 1'b0, 11'd0,    -1, TBL_KEEP, -1, 16'h0000}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_in_word;
    logic        i_first_word;
    logic [10:0] i_block_symbols;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_out_word;
    logic        o_last;
    logic        o_block_end;

    // model copy of the registers
    logic [2:0]  cfg_nbits = 3'd6;
    logic [63:0] cfg_tbl [3] = '{64'd0, 64'd0, 64'd0};

    // model copy of the encoder state
    logic [2:0]  st_trellis = 3'd0;
    int unsigned st_in_bits = 0, st_in_cnt = 0;
    int unsigned st_out_bits = 0, st_out_cnt = 0;
    int unsigned st_left = 0;
    bit          st_active = 1'b0;

    t_enc_word   step_res [3];
    t_enc_word   pending_words [$];

    int  n_err = 0;
    int  words_in = 0, words_out = 0, blocks_done = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;       // no idling on either side
    bit  hold_req = 1'b0;   // ask the receiver for a long hold-off

    table_trellis_encoder_packer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_in_word       (i_in_word),
        .i_first_word    (i_first_word),
        .i_block_symbols (i_block_symbols),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_word      (o_out_word),
        .o_last          (o_last),
        .o_block_end     (o_block_end)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        n_err++;
        if (n_err <= 10) $display("tb: %s", msg);
    endtask

    // Encode one input word; fills step_res and returns the number of words
    function automatic int encode_word(logic [15:0] w, bit first, logic [10:0] cnt);
        int unsigned n, blen, sym, dibit, entry, osym;
        int          nres;
        logic [191:0] tbl;
        nres = 0;
        tbl  = {cfg_tbl[2], cfg_tbl[1], cfg_tbl[0]};
        n    = cfg_nbits;
        if (n < 2) n = 2;
        if (n > 6) n = 6;

        if (first) begin
            blen = (cnt > tte_pkg::MaxBlockSymbols) ? tte_pkg::MaxBlockSymbols : cnt;
            st_in_bits  = 0;
            st_in_cnt   = 0;
            st_out_bits = 0;
            st_out_cnt  = 0;
            st_left     = blen;
            st_active   = (blen != 0);
            if (!st_active) return 0;
        end else if (!st_active) begin
            return 0;
        end

        st_in_bits = ((st_in_bits << 16) | w) & 32'hFF_FFFF;
        st_in_cnt += 16;

        // symbol loop: dibit and state select the table entry
        while (st_in_cnt >= n && st_left > 0) begin
            st_in_cnt -= n;
            sym   = (st_in_bits >> st_in_cnt) & ((1 << n) - 1);
            st_in_bits &= (1 << st_in_cnt) - 1;
            dibit = (sym >> (n - 2)) & 3;
            entry = tbl[6 * (st_trellis * 4 + dibit) +: 6];
            st_trellis = entry[2:0];
            osym = ((entry >> 3) << (n - 2)) | (sym & ((1 << (n - 2)) - 1));
            st_out_bits = ((st_out_bits << (n + 1)) | osym) & 32'hFF_FFFF;
            st_out_cnt += n + 1;
            st_left--;
            if (st_out_cnt >= 16) begin
                st_out_cnt -= 16;
                step_res[nres] = '{16'(st_out_bits >> st_out_cnt), 1'b0, 1'b0};
                nres++;
                st_out_bits &= (1 << st_out_cnt) - 1;
            end
        end

        // block close: pad any partial word
        if (st_left == 0) begin
            if (st_out_cnt > 0) begin
                step_res[nres] = '{16'(st_out_bits << (16 - st_out_cnt)), 1'b0, 1'b0};
                nres++;
            end
            for (int k = 0; k < nres; k++) step_res[k].blk_end = 1'b1;
            st_in_bits  = 0;
            st_in_cnt   = 0;
            st_out_bits = 0;
            st_out_cnt  = 0;
            st_active   = 1'b0;
        end
        if (nres > 0) step_res[nres - 1].last = 1'b1;
        return nres;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == tte_pkg::REG_SYMBOL_BITS) cfg_nbits = val[2:0];
        else if (idx == tte_pkg::REG_TABLE_0) cfg_tbl[0] = val;
        else if (idx == tte_pkg::REG_TABLE_1) cfg_tbl[1] = val;
        else cfg_tbl[2] = val;
    endtask

    task automatic load_table(input int mode);
        logic [63:0] v;
        for (int p = 0; p < 3; p++) begin
            case (mode)
                TBL_ONES: v = '1;
                TBL_ZERO: v = '0;
                default:  v = {$urandom, $urandom};
            endcase
            case (p)
                0:       write_reg(tte_pkg::REG_TABLE_0, v);
                1:       write_reg(tte_pkg::REG_TABLE_1, v);
                default: write_reg(tte_pkg::REG_TABLE_2, v);
            endcase
        end
    endtask

    // drop the request and wait for the block to drain before touching registers
    task automatic go_quiet();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Offer one input request, hold it until taken, then queue its results
    task automatic offer_word(input logic [15:0] w, input bit first, input logic [10:0] cnt,
                              input int typed_n, input logic [15:0] typed_word);
        int nres;
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 24) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_in_word       <= w;
        i_first_word    <= first;
        i_block_symbols <= cnt;
        do @(posedge i_clk); while (o_stall);
        words_in++;
        nres = encode_word(w, first, cnt);
        if (typed_n < 0) begin
            for (int k = 0; k < nres; k++) pending_words.push_back(step_res[k]);
        end else begin
            for (int k = 0; k < typed_n; k++)
                pending_words.push_back('{typed_word, 1'b1, 1'b1});
        end
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_stall <= !calm && ($urandom_range(99) < 24);
        end
    end

    // output check against the oldest expected word
    always @(posedge i_clk) begin : out_check
        t_enc_word e;
        if (i_rst_n && o_valid && !i_stall) begin
            words_out++;
            if (o_last && o_block_end) blocks_done++;
            if (pending_words.size() == 0) begin
                flag_error($sformatf("unexpected word %h last %b end %b",
                                     o_out_word, o_last, o_block_end));
            end else begin
                e = pending_words.pop_front();
                if (o_out_word !== e.word || o_last !== e.last || o_block_end !== e.blk_end)
                    flag_error($sformatf("word %0d: exp %h/%b/%b got %h/%b/%b", words_out,
                                         e.word, e.last, e.blk_end,
                                         o_out_word, o_last, o_block_end));
            end
        end
    end

    // watchdog on cycles with no request moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: watchdog expired, %0d words outstanding", pending_words.size());
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_dir_row    row;
        logic [15:0] w;
        logic [10:0] cnt;
        bit          first;
        int          r, taken;

        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        i_valid         = 1'b0;
        i_in_word       = '0;
        i_first_word    = 1'b0;
        i_block_symbols = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIR_ROWS[i];
            if (row.set_n >= 0 || row.tbl_mode != TBL_KEEP) begin
                go_quiet();
                if (row.set_n >= 0) write_reg(tte_pkg::REG_SYMBOL_BITS, 64'(row.set_n));
                if (row.tbl_mode != TBL_KEEP) load_table(row.tbl_mode);
            end
            offer_word(row.word, row.first, row.cnt, row.typed_n, row.typed_word);
        end

        // random phases, each with its own width and table
        for (int ph = 0; ph < PHASES; ph++) begin
            go_quiet();
            case (ph)
                0:       write_reg(tte_pkg::REG_SYMBOL_BITS, 64'd2);
                1:       write_reg(tte_pkg::REG_SYMBOL_BITS, 64'd6);
                2:       write_reg(tte_pkg::REG_SYMBOL_BITS, 64'd7);
                4:       write_reg(tte_pkg::REG_SYMBOL_BITS, 64'd1);
                default: write_reg(tte_pkg::REG_SYMBOL_BITS, 64'($urandom_range(7)));
            endcase
            case (ph)
                2:       load_table(TBL_ONES);
                4:       load_table(TBL_ZERO);
                default: load_table(TBL_RAND);
            endcase
            calm  = (ph == 3);
            taken = 0;
            while (taken < PHASE_ITEMS) begin
                if (ph == 1 && taken == 5) hold_req = 1'b1;
                if (ph == 4 && taken == 10) begin
                    @(negedge i_clk);
                    i_valid <= 1'b0;
                    while (pending_words.size() != 0) @(posedge i_clk);
                end

                case ($urandom_range(9))
                    0:       w = 16'h0000;
                    1:       w = 16'hFFFF;
                    default: w = 16'($urandom_range(65535));
                endcase
                r = $urandom_range(99);
                if (!st_active) first = (r >= 10);   // a few stray idle words
                else first = (r < 8);                // occasional restart mid-block
                r = $urandom_range(99);
                if (r < 4)       cnt = 11'd0;
                else if (r < 9)  cnt = 11'($urandom_range(2047, 1025));
                else if (r < 20) cnt = 11'($urandom_range(200, 25));
                else             cnt = 11'($urandom_range(24, 1));

                if (first || st_active) taken++;
                offer_word(w, first, cnt, -1, 16'h0000);
            end
        end
        calm = 1'b0;

        // drain and let any late word show up
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        if (pending_words.size() != 0)
            flag_error($sformatf("%0d expected words never arrived", pending_words.size()));

        $display("tb: %0d input words taken, %0d output words checked, %0d blocks closed",
                 words_in, words_out, blocks_done);
        $display("tb: widths 0..7, zero/ones/random tables, %0d mismatches", n_err);
        if (n_err == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
